/* rtl/core/cbspl_pkg.sv */
`default_nettype none

package cbspl_pkg;

    // width of the sample index field
    localparam int SI_BITS = 7;

    // window shape
    localparam int N_TAPS = 4;
    localparam int N_AXES = 3;

    // weight pipeline depth after the sample index is latched
    localparam int WGT_CYCLES = 4;

    // multiply steps: four taps for each of three axes
    localparam int MAC_STEPS = 12;

    // divide steps: quotient estimate, then remainder
    localparam int DIV_CYCLES = 2;

    // opcodes
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WGT,
        S_MAC,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic       push;
        logic       eval_accept;
        logic       acc_clear;
        logic       mac_en;
        logic [1:0] mac_tap;
        logic [1:0] mac_axis;
        logic       acc_en;
        logic       div_init;
        logic       div_step;
        logic       load_out;
    } t_cmd;

    typedef struct packed {
        logic full;
    } t_status;

endpackage

`default_nettype wire

/* rtl/core/cbspl_ctrl.sv */
`default_nettype none

module cbspl_ctrl
    import cbspl_pkg::*;
(
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_valid,
    input  wire     i_opcode,
    output logic    o_stall,
    output logic    o_valid,
    input  wire     i_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam int CTW = $clog2(MAC_STEPS + 1);

    t_state           r_state, n_state;
    logic [CTW-1:0]   r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_opcode == OP_PUSH) begin
                        o_cmd.push = 1'b1;
                    end else begin
                        o_cmd.eval_accept = 1'b1;
                        n_cnt             = '0;
                        n_state           = i_status.full ? S_WGT : S_DONE;
                    end
                end
            end
            S_WGT: begin
                o_cmd.acc_clear = 1'b1;
                if (r_cnt == CTW'(WGT_CYCLES - 1)) begin
                    n_cnt   = '0;
                    n_state = S_MAC;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_MAC: begin
                // product of step k is registered and added in the following cycle
                if (r_cnt < CTW'(MAC_STEPS)) begin
                    o_cmd.mac_en   = 1'b1;
                    o_cmd.mac_tap  = r_cnt[1:0];
                    o_cmd.mac_axis = r_cnt[3:2];
                end
                if (r_cnt != '0) begin
                    o_cmd.acc_en = 1'b1;
                end
                if (r_cnt == CTW'(MAC_STEPS)) begin
                    n_cnt   = '0;
                    n_state = S_DIV;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DIV: begin
                if (r_cnt == '0) begin
                    o_cmd.div_init = 1'b1;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
                if (r_cnt == CTW'(DIV_CYCLES - 1)) begin
                    n_cnt   = '0;
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

endmodule

`default_nettype wire

/* rtl/core/cbspl_dpath.sv */
`default_nettype none

module cbspl_dpath
    import cbspl_pkg::*;
#(
    parameter int SAMPLES_PER_SEGMENT = 100,
    parameter int COORD_BITS          = 16
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  t_cmd                        i_cmd,
    output t_status                     o_status,
    input  wire signed [COORD_BITS-1:0] i_point_x,
    input  wire signed [COORD_BITS-1:0] i_point_y,
    input  wire signed [COORD_BITS-1:0] i_point_z,
    input  wire        [SI_BITS-1:0]    i_sample_index,
    output logic signed [COORD_BITS-1:0] o_curve_x,
    output logic signed [COORD_BITS-1:0] o_curve_y,
    output logic signed [COORD_BITS-1:0] o_curve_z,
    output logic                        o_not_ready
);

    localparam int CB = COORD_BITS;
    localparam longint unsigned DL   = SAMPLES_PER_SEGMENT - 1;
    localparam longint unsigned D3   = DL * DL * DL;
    localparam longint unsigned DEN  = 6 * D3;
    localparam longint unsigned HALF = DEN / 2;
    localparam longint unsigned D3X4 = 4 * D3;
    localparam int DB = $clog2(SAMPLES_PER_SEGMENT);
    localparam int WB = $clog2(DEN + 1);
    localparam int XB = WB + 2;
    localparam int AB = WB + CB;
    localparam int JW = (DB > SI_BITS) ? DB : SI_BITS;
    localparam int LB = WB - 1;
    localparam int HB = AB - LB;
    localparam int MB = CB + 2;
    localparam int PB = HB + MB;
    // reciprocal of the divisor scaled by 2^AB
    localparam logic [AB:0]   POW_AB = {1'b1, {AB{1'b0}}};
    localparam logic [MB-1:0] RECIP  = MB'(POW_AB / (AB+1)'(DEN));

    // control point window, tap 0 oldest
    logic [CB-1:0]   r_win [N_TAPS][N_AXES];
    logic [2:0]      r_held;
    logic            r_nr;

    // weight pipeline
    logic [DB-1:0]   r_jc, r_m;
    logic [2*DB-1:0] r_j2, r_m2;
    logic [3*DB-1:0] r_j3, r_m3, r_j2d;
    logic [WB-1:0]   r_w [N_TAPS];

    logic [JW-1:0]   j_ext;
    logic [DB-1:0]   n_jc;
    logic [2*DB-1:0] n_j2, n_m2;
    logic [3*DB-1:0] n_j3, n_m3, n_j2d;
    logic [XB-1:0]   n_w1x;

    // multiply-accumulate
    logic [CB-1:0]   u_sel;
    logic [AB-1:0]   n_prod, r_prod;
    logic [1:0]      r_prod_axis;
    logic [AB-1:0]   r_acc [N_AXES];

    // reciprocal dividers, one per axis
    logic [PB-1:0]   div_prod [N_AXES];
    logic [CB-1:0]   div_q    [N_AXES];
    logic [CB-1:0]   r_qe     [N_AXES];
    logic [WB+1:0]   r_rem    [N_AXES];

    logic [CB-1:0]   r_curve [N_AXES];
    logic [CB-1:0]   pt_in [N_AXES];

    assign pt_in[0] = i_point_x;
    assign pt_in[1] = i_point_y;
    assign pt_in[2] = i_point_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else if (i_cmd.push && !r_held[2]) begin
            r_held <= r_held + 1'b1;
        end
    end

    assign o_status.full = r_held[2];

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            for (int k = 0; k < N_TAPS - 1; k++) begin
                for (int a = 0; a < N_AXES; a++) begin
                    r_win[k][a] <= r_win[k+1][a];
                end
            end
            for (int a = 0; a < N_AXES; a++) begin
                r_win[N_TAPS-1][a] <= pt_in[a];
            end
        end
    end

    // sample index clamped to the segment end
    assign j_ext = JW'(i_sample_index);
    assign n_jc  = (j_ext > JW'(DL)) ? DB'(DL) : DB'(j_ext);

    assign n_j2  = r_jc * r_jc;
    assign n_m2  = r_m * r_m;
    assign n_j3  = r_j2 * r_jc;
    assign n_m3  = r_m2 * r_m;
    assign n_j2d = r_j2 * DB'(DL);
    // 3 j^3 - 6 j^2 d + 4 d^3, never negative
    assign n_w1x = (XB'(r_j3) << 1) + XB'(r_j3) + XB'(D3X4)
                 - (XB'(r_j2d) << 2) - (XB'(r_j2d) << 1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval_accept) begin
            r_jc <= n_jc;
            r_m  <= DB'(DL) - n_jc;
            r_nr <= !r_held[2];
        end
        r_j2   <= n_j2;
        r_m2   <= n_m2;
        r_j3   <= n_j3;
        r_m3   <= n_m3;
        r_j2d  <= n_j2d;
        r_w[0] <= WB'(r_m3);
        r_w[1] <= WB'(n_w1x);
        r_w[3] <= WB'(r_j3);
        // weights sum to 6 d^3
        r_w[2] <= WB'(DEN) - r_w[0] - r_w[1] - r_w[3];
    end

    // coordinates offset to unsigned so every product is unsigned
    always_comb begin
        u_sel = '0;
        for (int a = 0; a < N_AXES; a++) begin
            if (i_cmd.mac_axis == 2'(a)) begin
                u_sel = r_win[i_cmd.mac_tap][a] ^ {1'b1, {(CB-1){1'b0}}};
            end
        end
    end

    assign n_prod = AB'(r_w[i_cmd.mac_tap]) * AB'(u_sel);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mac_en) begin
            r_prod      <= n_prod;
            r_prod_axis <= i_cmd.mac_axis;
        end
        for (int a = 0; a < N_AXES; a++) begin
            if (i_cmd.acc_clear) begin
                r_acc[a] <= AB'(HALF);
            end else if (i_cmd.acc_en && r_prod_axis == 2'(a)) begin
                r_acc[a] <= r_acc[a] + r_prod;
            end
        end
    end

    // top bits times the reciprocal land at most two below the quotient,
    // the remainder then picks the correction
    always_comb begin
        for (int a = 0; a < N_AXES; a++) begin
            div_prod[a] = PB'(r_acc[a][AB-1:LB]) * PB'(RECIP);
            if (r_rem[a] >= (WB+2)'(2 * DEN)) begin
                div_q[a] = r_qe[a] + CB'(2);
            end else if (r_rem[a] >= (WB+2)'(DEN)) begin
                div_q[a] = r_qe[a] + CB'(1);
            end else begin
                div_q[a] = r_qe[a];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < N_AXES; a++) begin
            if (i_cmd.div_init) begin
                r_qe[a] <= div_prod[a][HB+CB-1:HB];
            end
            if (i_cmd.div_step) begin
                r_rem[a] <= (WB+2)'(r_acc[a] - AB'(r_qe[a]) * AB'(DEN));
            end
        end
    end

    // convex blend stays in range: removing the offset is a sign flip
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            for (int a = 0; a < N_AXES; a++) begin
                r_curve[a] <= r_nr ? '0 : (div_q[a] ^ {1'b1, {(CB-1){1'b0}}});
            end
            o_not_ready <= r_nr;
        end
    end

    assign o_curve_x = r_curve[0];
    assign o_curve_y = r_curve[1];
    assign o_curve_z = r_curve[2];

endmodule

`default_nettype wire

/* rtl/core/cubic_bspline_point_eval.sv */
// push word: accepted without a stall, pushes may follow back to back
// evaluate word: stall stays high while it is worked on, result valid the cycle after;
//   the weight pipeline, the shared multiplier (12 products) and the reciprocal
//   divide run in turn; a held result keeps the stall high until it is taken
// evaluate with fewer than four points: goes straight to the output load, result flagged not ready
// synchronous active-low reset clears the point count, state and output valid
`default_nettype none

module cubic_bspline_point_eval
    import cbspl_pkg::*;
#(
    parameter int SAMPLES_PER_SEGMENT = 100,
    parameter int COORD_BITS          = 16
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_stall,
    input  wire                          i_opcode,
    input  wire signed [COORD_BITS-1:0]  i_point_x,
    input  wire signed [COORD_BITS-1:0]  i_point_y,
    input  wire signed [COORD_BITS-1:0]  i_point_z,
    input  wire        [SI_BITS-1:0]     i_sample_index,
    output logic                         o_valid,
    input  wire                          i_stall,
    output logic signed [COORD_BITS-1:0] o_curve_x,
    output logic signed [COORD_BITS-1:0] o_curve_y,
    output logic signed [COORD_BITS-1:0] o_curve_z,
    output logic                         o_not_ready
);

    t_cmd    cmd;
    t_status status;

    cbspl_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_opcode (i_opcode),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    cbspl_dpath #(
        .SAMPLES_PER_SEGMENT (SAMPLES_PER_SEGMENT),
        .COORD_BITS          (COORD_BITS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_point_x      (i_point_x),
        .i_point_y      (i_point_y),
        .i_point_z      (i_point_z),
        .i_sample_index (i_sample_index),
        .o_curve_x      (o_curve_x),
        .o_curve_y      (o_curve_y),
        .o_curve_z      (o_curve_z),
        .o_not_ready    (o_not_ready)
    );

    // a new result is loaded only from the busy state
    a_load_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result appeared without a busy cycle");

    // pushes never make the block busy
    a_push_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_opcode == OP_PUSH) |=> !o_stall)
        else $error("push left the block busy");

    // a not-ready result carries a zero point
    a_not_ready_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_not_ready) |->
            (o_curve_x == '0 && o_curve_y == '0 && o_curve_z == '0))
        else $error("not-ready result with nonzero point");

endmodule

`default_nettype wire

/* test/tb_cubic_bspline_point_eval.sv */
`timescale 1ns / 100ps

module tb_cubic_bspline_point_eval;
    import cbspl_pkg::*;

    localparam int SAMPLES_PER_SEGMENT = 100;
    localparam int COORD_BITS          = 16;
    localparam int N_RANDOM            = 1530;
    localparam int CALM_TAIL           = 200;
    localparam int HOLD_AT             = 400;
    localparam int HOLD_CYCLES         = 80;
    localparam int DRAIN_CYCLES        = 50;
    localparam int MAX_PRINTED         = 100;
    localparam longint COORD_HALF      = 64'sd1 << (COORD_BITS - 1);

    typedef logic signed [COORD_BITS-1:0] t_coord;

    localparam t_coord ZC   = '0;
    localparam t_coord MAXC = 16'sh7fff;
    localparam t_coord MINC = 16'sh8000;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
        logic   nr;
    } t_curve;

    // one input word plus an optional typed-in expectation
    typedef struct packed {
        logic               op;
        t_coord             x;
        t_coord             y;
        t_coord             z;
        logic [SI_BITS-1:0] j;
        logic               chk;
        t_coord             ex;
        t_coord             ey;
        t_coord             ez;
        logic               enr;
    } t_word;

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_valid        = 1'b0;
    logic               o_stall;
    logic               i_opcode       = OP_PUSH;
    t_coord             i_point_x      = '0;
    t_coord             i_point_y      = '0;
    t_coord             i_point_z      = '0;
    logic [SI_BITS-1:0] i_sample_index = '0;
    logic               o_valid;
    logic               i_stall        = 1'b0;
    t_coord             o_curve_x;
    t_coord             o_curve_y;
    t_coord             o_curve_z;
    logic               o_not_ready;

    cubic_bspline_point_eval #(
        .SAMPLES_PER_SEGMENT(SAMPLES_PER_SEGMENT),
        .COORD_BITS         (COORD_BITS)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_opcode      (i_opcode),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_point_z     (i_point_z),
        .i_sample_index(i_sample_index),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_curve_x     (o_curve_x),
        .o_curve_y     (o_curve_y),
        .o_curve_z     (o_curve_z),
        .o_not_ready   (o_not_ready)
    );

    // reset state, filling window, identical points, clamped index, mixed points
    t_word dir_tab [21] = '{
        '{OP_EVAL, 16'sh1234, 16'sh5678, 16'sh0f0f, 7'd0,   1'b1, ZC, ZC, ZC, 1'b1},
        '{OP_PUSH, MAXC, MINC, ZC, 7'd127,                  1'b0, ZC, ZC, ZC, 1'b0},
        '{OP_EVAL, ZC, ZC, ZC, 7'd99,                       1'b1, ZC, ZC, ZC, 1'b1},
        '{OP_PUSH, MAXC, MINC, ZC, 7'd5,                    1'b0, ZC, ZC, ZC, 1'b0},
        '{OP_PUSH, MAXC, MINC, ZC, 7'd64,                   1'b0, ZC, ZC, ZC, 1'b0},
        '{OP_EVAL, MINC, MAXC, MAXC, 7'd50,                 1'b1, ZC, ZC, ZC, 1'b1},
        '{OP_PUSH, MAXC, MINC, ZC, 7'd0,                    1'b0, ZC, ZC, ZC, 1'b0},
        '{OP_EVAL, ZC, ZC, ZC, 7'd0,                        1'b1, MAXC, MINC, ZC, 1'b0},
        '{OP_EVAL, ZC, ZC, ZC, 7'd99,                       1'b1, MAXC, MINC, ZC, 1'b0},
        '{OP_EVAL, MAXC, MAXC, MAXC, 7'd127,                1'b1, MAXC, MINC, ZC, 1'b0},
        '{OP_PUSH, MINC, MAXC, 16'shffff, 7'd99,            1'b0, ZC, ZC, ZC, 1'b0},
        '{OP_EVAL, ZC, ZC, ZC, 7'd0,                        1'b0, ZC, ZC, ZC, 1'b0},
        '{OP_EVAL, ZC, ZC, ZC, 7'd100,                      1'b0, ZC, ZC, ZC, 1'b0},
        '{OP_PUSH, 16'sh4000, 16'shc000, 16'sh0001, 7'd1,   1'b0, ZC, ZC, ZC, 1'b0},
        '{OP_PUSH, 16'shc000, 16'sh4000, 16'sd12345, 7'd2,  1'b0, ZC, ZC, ZC, 1'b0},
        '{OP_EVAL, ZC, ZC, ZC, 7'd1,                        1'b0, ZC, ZC, ZC, 1'b0},
        '{OP_EVAL, ZC, ZC, ZC, 7'd98,                       1'b0, ZC, ZC, ZC, 1'b0},
        '{OP_EVAL, ZC, ZC, ZC, 7'd127,                      1'b0, ZC, ZC, ZC, 1'b0},
        '{OP_PUSH, ZC, ZC, ZC, 7'd77,                       1'b0, ZC, ZC, ZC, 1'b0},
        '{OP_EVAL, ZC, ZC, ZC, 7'd49,                       1'b0, ZC, ZC, ZC, 1'b0},
        '{OP_EVAL, MINC, MINC, MINC, 7'd64,                 1'b0, ZC, ZC, ZC, 1'b0}
    };

    t_word  stim_q [$];
    t_curve curve_q [$];

    // predictor state: oldest point in slot 0
    t_coord win [4][3];
    int     held = 0;

    t_word  cur_word;
    t_curve want_c;
    int     next_idx   = 0;
    int     sent_count = 0;
    int     gap_left   = 0;
    int     stall_left = 0;
    int     err_count  = 0;
    logic   calm       = 1'b0;
    logic   long_hold  = 1'b0;

    task automatic report_mismatch(input string what, input int got, input int want);
        err_count++;
        if (err_count <= MAX_PRINTED) begin
            $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        end
    endtask

    function automatic t_curve bspline_point(input logic [SI_BITS-1:0] j_in);
        longint d, j, m, den, acc, q;
        longint w [4];
        longint p [3];
        int     a, k;
        t_curve c;
        d = SAMPLES_PER_SEGMENT - 1;
        j = j_in;
        if (j > d) begin
            j = d;
        end
        m    = d - j;
        w[0] = m * m * m;
        w[1] = 3 * j * j * j - 6 * j * j * d + 4 * d * d * d;
        w[2] = -3 * j * j * j + 3 * j * j * d + 3 * j * d * d + d * d * d;
        w[3] = j * j * j;
        den  = 6 * d * d * d;
        for (a = 0; a < 3; a++) begin
            // offset coordinates keep the sum non-negative, so division floors
            acc = 0;
            for (k = 0; k < 4; k++) begin
                acc += w[k] * (longint'(win[k][a]) + COORD_HALF);
            end
            q = (acc + den / 2) / den - COORD_HALF;
            if (q > COORD_HALF - 1) begin
                q = COORD_HALF - 1;
            end
            if (q < -COORD_HALF) begin
                q = -COORD_HALF;
            end
            p[a] = q;
        end
        c.x  = p[0][COORD_BITS-1:0];
        c.y  = p[1][COORD_BITS-1:0];
        c.z  = p[2][COORD_BITS-1:0];
        c.nr = 1'b0;
        return c;
    endfunction

    task automatic absorb_word(input t_word w);
        t_curve c;
        int     k;
        if (w.op == OP_PUSH) begin
            for (k = 0; k < 3; k++) begin
                win[k] = win[k+1];
            end
            win[3][0] = w.x;
            win[3][1] = w.y;
            win[3][2] = w.z;
            if (held < 4) begin
                held++;
            end
        end else begin
            if (held < 4) begin
                c = '{ZC, ZC, ZC, 1'b1};
            end else begin
                c = bspline_point(w.j);
            end
            if (w.chk) begin
                c = '{w.ex, w.ey, w.ez, w.enr};
            end
            curve_q = {curve_q, c};
        end
    endtask

    function automatic t_coord rand_coord();
        int pick;
        pick = $urandom_range(0, 15);
        if (pick == 0) begin
            return MAXC;
        end else if (pick == 1) begin
            return MINC;
        end
        return t_coord'($urandom());
    endfunction

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #(10_000_000);
        $display("cubic_bspline_point_eval regression: fail");
        $finish;
    end

    // sender: offers words, predicts each accepted one
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                absorb_word(cur_word);
                sent_count++;
            end
            if (!i_valid || !o_stall) begin
                if (gap_left != 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (next_idx < stim_q.size()) begin
                    if (!calm && $urandom_range(0, 9) == 0) begin
                        gap_left = $urandom_range(0, 6);
                        i_valid <= 1'b0;
                    end else begin
                        cur_word = stim_q[next_idx];
                        next_idx++;
                        i_opcode       <= cur_word.op;
                        i_point_x      <= cur_word.x;
                        i_point_y      <= cur_word.y;
                        i_point_z      <= cur_word.z;
                        i_sample_index <= cur_word.j;
                        i_valid        <= 1'b1;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
            calm <= (next_idx + CALM_TAIL >= stim_q.size());
        end
    end

    // receiver stall bursts
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_stall    <= 1'b1;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 6);
            i_stall    <= 1'b1;
        end else begin
            i_stall <= long_hold;
        end
    end

    // long receiver hold-off so the block backs up into its input
    initial begin
        while (sent_count < HOLD_AT) begin
            @(posedge i_clk);
        end
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        long_hold <= 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (curve_q.size() == 0) begin
                report_mismatch("unexpected result word", 1, 0);
            end else begin
                want_c = curve_q.pop_front();
                if (o_curve_x !== want_c.x) begin
                    report_mismatch("curve_x", o_curve_x, want_c.x);
                end
                if (o_curve_y !== want_c.y) begin
                    report_mismatch("curve_y", o_curve_y, want_c.y);
                end
                if (o_curve_z !== want_c.z) begin
                    report_mismatch("curve_z", o_curve_z, want_c.z);
                end
                if (o_not_ready !== want_c.nr) begin
                    report_mismatch("not_ready", o_not_ready, want_c.nr);
                end
            end
        end
    end

    initial begin
        t_word w;
        int    r;
        for (int k = 0; k < 4; k++) begin
            for (int a = 0; a < 3; a++) begin
                win[k][a] = '0;
            end
        end
        foreach (dir_tab[i]) begin
            stim_q = {stim_q, dir_tab[i]};
        end
        for (r = 0; r < N_RANDOM; r++) begin
            w     = '0;
            w.op  = ($urandom_range(0, 9) < 4) ? OP_PUSH : OP_EVAL;
            w.x   = rand_coord();
            w.y   = rand_coord();
            w.z   = rand_coord();
            // mostly in-segment indices, some past the end
            w.j   = ($urandom_range(0, 7) == 0) ? SI_BITS'($urandom_range(100, 127))
                                                : SI_BITS'($urandom_range(0, 99));
            stim_q = {stim_q, w};
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (sent_count < stim_q.size()) begin
            @(posedge i_clk);
        end
        while (curve_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (curve_q.size() != 0) begin
            report_mismatch("leftover expected words", curve_q.size(), 0);
        end
        if (err_count == 0) begin
            $display("cubic_bspline_point_eval regression: pass");
        end else begin
            $display("cubic_bspline_point_eval regression: fail");
        end
        $finish;
    end

endmodule
